[design/ncr_pkg.sv]
// shared constants and types for the numeric character reference decoder
package ncr_pkg;

  localparam int DecDigits = 8;
  localparam int HexDigits = 7;
  localparam int MaxOut    = 5;
  localparam int CodeW     = 28;
  localparam int CntW      = $clog2((DecDigits > HexDigits ? DecDigits : HexDigits) + 1);
  localparam int NumW      = $clog2(MaxOut + 1);

  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [NumW-1:0]        n;
  } burst_t;

endpackage

[design/ncr_parse.sv]
// reference parser: holds parse state and builds the output bytes for one request
module ncr_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          end_of_stream,
  output ncr_pkg::burst_t burst
);

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_AMP,
    MODE_HASH,
    MODE_DEC,
    MODE_HEX
  } mode_t;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChSemi = 8'h3b;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChUpX  = 8'h58;

  mode_t                     mode;
  mode_t                     mode_next;
  logic [ncr_pkg::CodeW-1:0] code;
  logic [ncr_pkg::CodeW-1:0] code_next;
  logic [ncr_pkg::CntW-1:0]  cnt;
  logic [ncr_pkg::CntW-1:0]  cnt_next;
  logic [7:0]                marker;
  logic [7:0]                marker_next;

  logic [3:0][7:0]           enc_bytes;
  logic [ncr_pkg::NumW-1:0]  enc_len;
  logic [3:0][7:0]           pre_bytes;
  logic [ncr_pkg::NumW-1:0]  pre_len;
  logic                      fall;
  logic                      add_plain;
  logic                      eos;
  logic                      is_d;
  logic                      is_h;
  logic                      zero_hold;
  logic [3:0]                dval;
  logic [3:0]                hval;
  logic [ncr_pkg::CodeW-1:0] code_x10;

  function automatic logic f_is_dec(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic f_is_hex(input logic [7:0] b);
    logic [7:0] u;
    u = b & 8'hdf;
    return f_is_dec(b) || ((u >= 8'h41) && (u <= 8'h46));
  endfunction

  function automatic logic [3:0] f_hex_val(input logic [7:0] b);
    logic [7:0] t;
    if (f_is_dec(b)) begin
      t = b - 8'h30;
    end else begin
      t = (b | 8'h20) - 8'h61 + 8'd10;
    end
    return t[3:0];
  endfunction

  // utf-8 form of the held code point, or the replacement character ef bf bd above 0x10ffff
  always_comb begin
    enc_bytes = '0;
    enc_len   = '0;
    if (code > ncr_pkg::CodeW'(32'h10ffff)) begin
      enc_bytes[0] = 8'hef;
      enc_bytes[1] = 8'hbf;
      enc_bytes[2] = 8'hbd;
      enc_len      = ncr_pkg::NumW'(3);
    end else if (code <= ncr_pkg::CodeW'(32'h7f)) begin
      enc_bytes[0] = code[7:0];
      enc_len      = ncr_pkg::NumW'(1);
    end else if (code <= ncr_pkg::CodeW'(32'h7ff)) begin
      enc_bytes[0] = 8'hc0 | {3'b000, code[10:6]};
      enc_bytes[1] = 8'h80 | {2'b00, code[5:0]};
      enc_len      = ncr_pkg::NumW'(2);
    end else if (code <= ncr_pkg::CodeW'(32'hffff)) begin
      enc_bytes[0] = 8'he0 | {4'h0, code[15:12]};
      enc_bytes[1] = 8'h80 | {2'b00, code[11:6]};
      enc_bytes[2] = 8'h80 | {2'b00, code[5:0]};
      enc_len      = ncr_pkg::NumW'(3);
    end else begin
      enc_bytes[0] = 8'hf0 | {5'b00000, code[20:18]};
      enc_bytes[1] = 8'h80 | {2'b00, code[17:12]};
      enc_bytes[2] = 8'h80 | {2'b00, code[11:6]};
      enc_bytes[3] = 8'h80 | {2'b00, code[5:0]};
      enc_len      = ncr_pkg::NumW'(4);
    end
  end

  assign eos       = end_of_stream;
  assign is_d      = f_is_dec(in_byte);
  assign is_h      = f_is_hex(in_byte);
  assign dval      = in_byte[3:0];
  assign hval      = f_hex_val(in_byte);
  assign zero_hold = (cnt == ncr_pkg::CntW'(1)) && (code == '0) && (in_byte == ChZero);
  assign code_x10  = (code << 3) + (code << 1);

  always_comb begin
    mode_next   = mode;
    code_next   = code;
    cnt_next    = cnt;
    marker_next = marker;
    pre_bytes   = '0;
    pre_len     = '0;
    fall        = 1'b0;
    unique case (mode)
      MODE_AMP: begin
        if (!eos && in_byte == ChHash) begin
          mode_next = MODE_HASH;
        end else begin
          pre_bytes[0] = ChAmp;
          pre_len      = ncr_pkg::NumW'(1);
          mode_next    = MODE_PLAIN;
          fall         = 1'b1;
        end
      end
      MODE_HASH: begin
        if (!eos && (in_byte & 8'hdf) == ChUpX) begin
          marker_next = in_byte;
          code_next   = '0;
          cnt_next    = '0;
          mode_next   = MODE_HEX;
        end else if (!eos && is_d) begin
          code_next = ncr_pkg::CodeW'(dval);
          cnt_next  = ncr_pkg::CntW'(1);
          mode_next = MODE_DEC;
        end else begin
          pre_bytes[0] = ChAmp;
          pre_bytes[1] = ChHash;
          pre_len      = ncr_pkg::NumW'(2);
          mode_next    = MODE_PLAIN;
          fall         = 1'b1;
        end
      end
      MODE_DEC: begin
        if (!eos && is_d) begin
          if (!zero_hold && cnt < ncr_pkg::CntW'(ncr_pkg::DecDigits)) begin
            code_next = code_x10 + ncr_pkg::CodeW'(dval);
            cnt_next  = cnt + ncr_pkg::CntW'(1);
          end
        end else begin
          pre_bytes = enc_bytes;
          pre_len   = enc_len;
          mode_next = MODE_PLAIN;
          fall      = !(!eos && in_byte == ChSemi);
        end
      end
      MODE_HEX: begin
        if (!eos && is_h) begin
          if (!zero_hold && cnt < ncr_pkg::CntW'(ncr_pkg::HexDigits)) begin
            code_next = {code[ncr_pkg::CodeW-5:0], hval};
            cnt_next  = cnt + ncr_pkg::CntW'(1);
          end
        end else begin
          mode_next = MODE_PLAIN;
          if (cnt == '0) begin
            pre_bytes[0] = ChAmp;
            pre_bytes[1] = ChHash;
            pre_bytes[2] = marker;
            pre_len      = ncr_pkg::NumW'(3);
            fall         = 1'b1;
          end else begin
            pre_bytes = enc_bytes;
            pre_len   = enc_len;
            fall      = !(!eos && in_byte == ChSemi);
          end
        end
      end
      default: begin
        mode_next = MODE_PLAIN;
        fall      = 1'b1;
      end
    endcase

    add_plain = 1'b0;
    if (fall) begin
      if (eos) begin
        mode_next   = MODE_PLAIN;
        code_next   = '0;
        cnt_next    = '0;
        marker_next = '0;
      end else if (in_byte == ChAmp) begin
        mode_next = MODE_AMP;
        code_next = '0;
        cnt_next  = '0;
      end else begin
        add_plain = 1'b1;
      end
    end

    burst.bytes = '0;
    for (int i = 0; i < 4; i++) begin
      burst.bytes[i] = pre_bytes[i];
    end
    for (int i = 0; i < ncr_pkg::MaxOut; i++) begin
      if (add_plain && ncr_pkg::NumW'(i) == pre_len) begin
        burst.bytes[i] = in_byte;
      end
    end
    burst.n = pre_len + ncr_pkg::NumW'(add_plain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_PLAIN;
      code   <= '0;
      cnt    <= '0;
      marker <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      code   <= code_next;
      cnt    <= cnt_next;
      marker <= marker_next;
    end
  end

endmodule

[design/numeric_char_ref_to_utf8_top.sv]
// numeric character reference to utf-8 decoder, top level with output byte register
// the first byte of a request shows on the output in the cycle after the request is accepted
// throughput: one request per cycle while each yields at most one byte and rsp_stall is low; a
//   request that yields k bytes (up to 5) holds the output register until its last byte drains,
//   set by the single output byte register that drains one byte per cycle unless stalled
// reset: synchronous, clears parse state and drops any bytes not yet delivered
module numeric_char_ref_to_utf8_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_stream,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  ncr_pkg::burst_t                     burst;
  logic [ncr_pkg::MaxOut-1:0][7:0]     held;
  logic [ncr_pkg::NumW-1:0]            rem;
  logic                                req_acc;
  logic                                rsp_acc;
  logic                                draining;

  assign rsp_valid   = (rem != '0);
  assign out_byte    = held[0];
  assign last_of_run = (rem == ncr_pkg::NumW'(1));
  assign rsp_acc     = rsp_valid && !rsp_stall;
  assign draining    = last_of_run && !rsp_stall;
  assign req_stall   = rsp_valid && !draining;
  assign req_acc     = req_valid && !req_stall;

  ncr_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (req_acc),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .burst         (burst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (req_acc && burst.n != '0) begin
      rem <= burst.n;
    end else if (rsp_acc) begin
      rem <= rem - ncr_pkg::NumW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && burst.n != '0) begin
      held <= burst.bytes;
    end else if (rsp_acc) begin
      held <= held >> 8;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    req_acc |-> (!rsp_valid || (last_of_run && rsp_acc)))
    else $error("request taken while earlier bytes still pending");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= ncr_pkg::NumW'(ncr_pkg::MaxOut))
    else $error("pending byte count out of range");

  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    (rsp_acc && rem > ncr_pkg::NumW'(1)) |=> (rem == $past(rem) - ncr_pkg::NumW'(1)))
    else $error("pending byte count did not step down");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("output valid right after reset");

endmodule

[bench/numeric_char_ref_to_utf8_top_tb.sv]
// self-checking testbench for the numeric character reference to utf-8 decoder top level
`timescale 1ns / 100ps

module numeric_char_ref_to_utf8_top_tb;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 20;
  localparam int PhaseItems  = 95;
  localparam int NumPhases   = 5;

  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChUpperX = 8'h58;
  localparam logic [7:0] ChLowerX = 8'h78;
  localparam logic [7:0] CaseBit  = 8'h20;

  localparam logic [ncr_pkg::CodeW-1:0] MaxCode     = 28'h10FFFF;
  localparam logic [23:0]               Replacement = 24'hEFBFBD;

  typedef enum logic [2:0] {ModePlain, ModeAmp, ModeHash, ModeDec, ModeHex} mode_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    logic        typed;
    logic [2:0]  cnt;
    logic [39:0] want;
  } row_t;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       req_valid     = 1'b0;
  logic [7:0] in_byte       = 8'h00;
  logic       end_of_stream = 1'b0;
  logic       rsp_stall     = 1'b0;
  logic       req_stall;
  logic       rsp_valid;
  logic [7:0] out_byte;
  logic       last_of_run;

  numeric_char_ref_to_utf8_top dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed requests; typed rows carry their expected bytes left aligned in want
  row_t directed_rows [27] = '{
    '{8'h41,    1'b0, 1'b1, 3'd1, 40'h41_0000_0000},
    '{8'hA5,    1'b1, 1'b1, 3'd0, 40'h0},
    '{8'h00,    1'b0, 1'b1, 3'd1, 40'h00_0000_0000},
    '{8'hFF,    1'b0, 1'b1, 3'd1, 40'hFF_0000_0000},
    '{ChAmp,    1'b0, 1'b1, 3'd0, 40'h0},
    '{8'h61,    1'b0, 1'b1, 3'd2, 40'h2661_00_0000},
    '{ChAmp,    1'b0, 1'b1, 3'd0, 40'h0},
    '{ChHash,   1'b0, 1'b1, 3'd0, 40'h0},
    '{ChAmp,    1'b0, 1'b1, 3'd2, 40'h2623_00_0000},
    '{ChHash,   1'b0, 1'b1, 3'd0, 40'h0},
    '{ChUpperX, 1'b0, 1'b1, 3'd0, 40'h0},
    '{ChSemi,   1'b1, 1'b1, 3'd3, 40'h262358_0000},
    '{ChAmp,    1'b0, 1'b0, 3'd0, 40'h0},
    '{ChHash,   1'b0, 1'b0, 3'd0, 40'h0},
    '{ChZero,   1'b0, 1'b0, 3'd0, 40'h0},
    '{ChZero,   1'b0, 1'b0, 3'd0, 40'h0},
    '{ChNine,   1'b0, 1'b0, 3'd0, 40'h0},
    '{ChSemi,   1'b0, 1'b1, 3'd1, 40'h09_0000_0000},
    '{ChAmp,    1'b0, 1'b0, 3'd0, 40'h0},
    '{ChHash,   1'b0, 1'b0, 3'd0, 40'h0},
    '{ChLowerX, 1'b0, 1'b0, 3'd0, 40'h0},
    '{8'h31,    1'b0, 1'b0, 3'd0, 40'h0},
    '{ChUpperF, 1'b0, 1'b0, 3'd0, 40'h0},
    '{8'h36,    1'b0, 1'b0, 3'd0, 40'h0},
    '{ChZero,   1'b0, 1'b0, 3'd0, 40'h0},
    '{ChZero,   1'b0, 1'b0, 3'd0, 40'h0},
    '{8'h7A,    1'b0, 1'b0, 3'd0, 40'h0}
  };

  row_t        stim_q [$];
  int          phase_end [NumPhases];
  logic [7:0]  request_bytes [$];
  logic [7:0]  pending_bytes [$];
  logic        pending_lasts [$];
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  logic        hold_armed   = 1'b0;
  logic        hold_done    = 1'b0;

  // decoder state
  mode_t                     mode = ModePlain;
  logic [ncr_pkg::CodeW-1:0] code_acc = '0;
  logic [ncr_pkg::CntW-1:0]  kept_digits = '0;
  logic [7:0]                marker = 8'h00;

  function automatic logic is_dec_char(input logic [7:0] b);
    return b >= ChZero && b <= ChNine;
  endfunction

  function automatic logic is_hex_char(input logic [7:0] b);
    logic [7:0] u;
    u = b & ~CaseBit;
    return is_dec_char(b) || (u >= ChUpperA && u <= ChUpperF);
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [7:0] v;
    if (is_dec_char(b)) begin
      v = b - ChZero;
    end else begin
      v = (b | CaseBit) - ChLowerA + 8'd10;
    end
    return v[3:0];
  endfunction

  task automatic encode_code(input logic [ncr_pkg::CodeW-1:0] cp);
    if (cp > MaxCode) begin
      request_bytes.push_back(Replacement[23:16]);
      request_bytes.push_back(Replacement[15:8]);
      request_bytes.push_back(Replacement[7:0]);
    end else if (cp <= 28'h7F) begin
      request_bytes.push_back(cp[7:0]);
    end else if (cp <= 28'h7FF) begin
      request_bytes.push_back({3'b110, cp[10:6]});
      request_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp <= 28'hFFFF) begin
      request_bytes.push_back({4'b1110, cp[15:12]});
      request_bytes.push_back({2'b10, cp[11:6]});
      request_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      request_bytes.push_back({5'b11110, cp[20:18]});
      request_bytes.push_back({2'b10, cp[17:12]});
      request_bytes.push_back({2'b10, cp[11:6]});
      request_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  // bytes caused by one request go to request_bytes
  task automatic decode_request(input logic [7:0] b, input logic e);
    logic as_text;
    request_bytes.delete();
    as_text = 1'b1;
    case (mode)
      ModeAmp: begin
        if (!e && b == ChHash) begin
          mode = ModeHash;
          as_text = 1'b0;
        end else begin
          request_bytes.push_back(ChAmp);
          mode = ModePlain;
        end
      end
      ModeHash: begin
        if (!e && (b & ~CaseBit) == ChUpperX) begin
          marker = b;
          code_acc = '0;
          kept_digits = '0;
          mode = ModeHex;
          as_text = 1'b0;
        end else if (!e && is_dec_char(b)) begin
          code_acc = ncr_pkg::CodeW'(b - ChZero);
          kept_digits = ncr_pkg::CntW'(1);
          mode = ModeDec;
          as_text = 1'b0;
        end else begin
          request_bytes.push_back(ChAmp);
          request_bytes.push_back(ChHash);
          mode = ModePlain;
        end
      end
      ModeDec: begin
        if (!e && is_dec_char(b)) begin
          if (!(kept_digits == 1 && code_acc == 0 && b == ChZero) &&
              kept_digits < ncr_pkg::DecDigits) begin
            code_acc = ncr_pkg::CodeW'(code_acc * 10 + (b - ChZero));
            kept_digits++;
          end
          as_text = 1'b0;
        end else begin
          encode_code(code_acc);
          mode = ModePlain;
          if (!e && b == ChSemi) as_text = 1'b0;
        end
      end
      ModeHex: begin
        if (!e && is_hex_char(b)) begin
          if (!(kept_digits == 1 && code_acc == 0 && b == ChZero) &&
              kept_digits < ncr_pkg::HexDigits) begin
            code_acc = {code_acc[ncr_pkg::CodeW-5:0], hex_digit(b)};
            kept_digits++;
          end
          as_text = 1'b0;
        end else begin
          mode = ModePlain;
          if (kept_digits == 0) begin
            request_bytes.push_back(ChAmp);
            request_bytes.push_back(ChHash);
            request_bytes.push_back(marker);
          end else begin
            encode_code(code_acc);
            if (!e && b == ChSemi) as_text = 1'b0;
          end
        end
      end
      default: mode = ModePlain;
    endcase
    if (as_text) begin
      if (e) begin
        mode = ModePlain;
        code_acc = '0;
        kept_digits = '0;
        marker = 8'h00;
      end else if (b == ChAmp) begin
        mode = ModeAmp;
        code_acc = '0;
        kept_digits = '0;
      end else begin
        request_bytes.push_back(b);
      end
    end
  endtask

  task automatic add_item(input logic [7:0] data, input logic eos);
    row_t r;
    r = '0;
    r.data = data;
    r.eos = eos;
    stim_q.push_back(r);
  endtask

  function automatic logic [7:0] hex_ascii(input logic [3:0] v);
    if (v < 10) return ChZero + v;
    return ($urandom_range(1) ? ChUpperA : ChLowerA) + v - 8'd10;
  endfunction

  task automatic add_reference();
    logic       hex;
    int         ndigits;
    int         k;
    int         term;
    logic [7:0] ch;
    hex = 1'($urandom_range(1));
    add_item(ChAmp, 1'b0);
    add_item(ChHash, 1'b0);
    if (hex) add_item($urandom_range(1) ? ChUpperX : ChLowerX, 1'b0);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(4, 1)) add_item(ChZero, 1'b0);
    end
    ndigits = $urandom_range(10, 1);
    for (k = 0; k < ndigits; k++) begin
      if (hex) begin
        ch = hex_ascii(4'($urandom_range(15)));
      end else begin
        ch = ChZero + 8'($urandom_range(9));
      end
      add_item(ch, 1'b0);
    end
    term = $urandom_range(9);
    if (term < 5) begin
      add_item(ChSemi, 1'b0);
    end else if (term < 8) begin
      add_item(8'($urandom_range(255)), 1'b0);
    end else begin
      add_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // hex reference at a utf-8 length boundary, at a surrogate, or past the top code point
  task automatic add_corner_reference();
    logic [ncr_pkg::CodeW-1:0] cp;
    logic [3:0]                nib;
    logic                      started;
    int                        k;
    case ($urandom_range(10))
      0: cp = 28'h0;
      1: cp = 28'h7F;
      2: cp = 28'h80;
      3: cp = 28'h7FF;
      4: cp = 28'h800;
      5: cp = 28'hD800;
      6: cp = 28'hFFFF;
      7: cp = 28'h10000;
      8: cp = MaxCode;
      9: cp = MaxCode + 28'd1;
      default: cp = 28'hFFFFFFF;
    endcase
    add_item(ChAmp, 1'b0);
    add_item(ChHash, 1'b0);
    add_item(ChLowerX, 1'b0);
    started = 1'b0;
    for (k = 6; k >= 0; k--) begin
      nib = cp[4*k +: 4];
      if (nib != 0 || started || k == 0) begin
        add_item(hex_ascii(nib), 1'b0);
        started = 1'b1;
      end
    end
    add_item(ChSemi, 1'b0);
  endtask

  task automatic add_broken_prefix();
    int         depth;
    logic [7:0] b;
    depth = $urandom_range(2);
    add_item(ChAmp, 1'b0);
    if (depth >= 1) add_item(ChHash, 1'b0);
    if (depth == 2) add_item($urandom_range(1) ? ChUpperX : ChLowerX, 1'b0);
    if ($urandom_range(3) == 0) begin
      add_item(8'($urandom_range(255)), 1'b1);
    end else begin
      do begin
        b = 8'($urandom_range(255));
      end while ((depth == 0 && b == ChHash) ||
                 (depth == 1 && (is_dec_char(b) || (b & ~CaseBit) == ChUpperX)) ||
                 (depth == 2 && is_hex_char(b)));
      add_item(b, 1'b0);
    end
  endtask

  task automatic add_random_part(input int count);
    int target;
    int pick;
    target = stim_q.size() + count;
    while (stim_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        add_reference();
      end else if (pick < 52) begin
        add_corner_reference();
      end else if (pick < 64) begin
        add_broken_prefix();
      end else if (pick < 92) begin
        repeat ($urandom_range(6, 1)) add_item(8'($urandom_range(255)), 1'b0);
      end else begin
        add_item(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, and one long hold-off while the sender keeps going
  initial begin
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        repeat (HoldCycles) begin
          rsp_stall <= 1'b1;
          @(negedge clk);
        end
        hold_done = 1'b1;
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    row_t       cur;
    logic [7:0] want_byte;
    logic       want_last;
    int         k;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        cur = stim_q[accepted_cnt];
        decode_request(in_byte, end_of_stream);
        if (cur.typed) begin
          request_bytes.delete();
          for (k = 0; k < cur.cnt; k++) request_bytes.push_back(cur.want[39 - 8*k -: 8]);
        end
        for (k = 0; k < request_bytes.size(); k++) begin
          pending_bytes.push_back(request_bytes[k]);
          pending_lasts.push_back(k == request_bytes.size() - 1);
        end
        accepted_cnt++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, got out_byte %h last_of_run %b",
                   $time, out_byte, last_of_run);
          err_cnt++;
        end else begin
          want_byte = pending_bytes.pop_front();
          want_last = pending_lasts.pop_front();
          if (out_byte !== want_byte) begin
            $display("%0t: out_byte expected %h got %h", $time, want_byte, out_byte);
            err_cnt++;
          end
          if (last_of_run !== want_last) begin
            $display("%0t: last_of_run expected %b got %b", $time, want_last, last_of_run);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin : drive_requests
    int p;
    int i;
    for (i = 0; i < $size(directed_rows); i++) stim_q.push_back(directed_rows[i]);
    phase_end[0] = stim_q.size();
    for (p = 1; p < NumPhases; p++) begin
      add_random_part(PhaseItems);
      phase_end[p] = stim_q.size();
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    i = 0;
    for (p = 0; p < NumPhases; p++) begin
      case (p)
        2: begin
          idle_pct = 68;
          stall_pct = 0;
        end
        3: begin
          idle_pct = 0;
          stall_pct = 68;
        end
        4: begin
          idle_pct = 22;
          stall_pct = 22;
        end
        default: begin
          idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      if (p == 1) hold_armed = 1'b1;
      while (i < phase_end[p]) begin
        while ($urandom_range(99) < idle_pct) begin
          req_valid <= 1'b0;
          @(negedge clk);
        end
        req_valid <= 1'b1;
        in_byte <= stim_q[i].data;
        end_of_stream <= stim_q[i].eos;
        do @(negedge clk); while (accepted_cnt <= i);
        i++;
      end
      // pause until every byte of this phase has come out
      req_valid <= 1'b0;
      do @(negedge clk); while (pending_bytes.size() != 0);
    end

    repeat (DrainCycles) @(negedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
